@@ design/modular_exponentiation_assert.svh @@
// Assertion macros used by the checker file of the exponentiation block.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/mexp_pkg.sv @@
`default_nettype none

package mexp_pkg;

   localparam int WORD_BITS  = 32;
   localparam int COUNT_BITS = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [1:0]            op_type;

   // Destination and operand selection of one modular multiplication.
   localparam op_type OP_REDUCE = 2'd0;
   localparam op_type OP_MULT   = 2'd1;
   localparam op_type OP_SQUARE = 2'd2;

   localparam count_type LAST_COUNT = count_type'(WORD_BITS - 1);

   typedef struct packed {
      logic   load;
      logic   start;
      op_type start_op;
      logic   step;
      logic   publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic modulus_zero;
      logic mul_last;
      logic exp_zero;
      logic exp_lsb;
   } ctrl_status_type;

endpackage

`default_nettype wire

@@ design/mexp_if.sv @@
`default_nettype none

// Request channel: one base and exponent pair per transfer.
interface mexp_req_if import mexp_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type base_value;
   word_type exponent;

   modport source (output valid, output base_value, output exponent, input ready);
   modport sink (input valid, input base_value, input exponent, output ready);
endinterface

// Response channel: one residue per transfer.
interface mexp_rsp_if import mexp_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type residue;

   modport source (output valid, output residue, input ready);
   modport sink (input valid, input residue, output ready);
endinterface

`default_nettype wire

@@ design/modular_exponentiation.sv @@
// Modular exponentiation, residue = base_value ^ exponent mod modulus.
// The modulus is written through csr_write_enable and csr_write_data; the user
// must write it only while the block is idle, which the block itself does not
// enforce. It resets to one. A modulus of zero gives a residue of zero.
// Requests arrive on req_chan (base_value, exponent), one transfer per item;
// each request yields exactly one transfer on rsp_chan carrying the residue.
// The exponent is scanned from its least significant bit. A shared add-and-double
// modular multiplier handles one multiplier bit per cycle; each modular product
// is set up and then stepped through the 32 bits of its multiplier. The first
// product reduces the base, every set exponent bit costs a multiply and every
// bit below the top one costs a square.
// One item is in work at a time; the next request is taken once the state
// returns to idle after the result enters the output register. That register
// holds a finished residue while the receiver stalls, so one more item can be
// accepted and computed, and it then waits until the older result is taken.
// Synchronous reset returns to idle with no response pending.
`default_nettype none

module modular_exponentiation import mexp_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      csr_write_enable,
   input  wire word_type  csr_write_data,
   mexp_req_if.sink       req_chan,
   mexp_rsp_if.source     rsp_chan
);

   // Command and status between the sequencer and the arithmetic.
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // The sequencer owns the handshakes and walks the exponent bits.
   mexp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the modulus, the accumulator, the running square, the
   // remaining exponent, the shared multiplier and the output register.
   mexp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .base_value       (req_chan.base_value),
      .exponent         (req_chan.exponent),
      .cmd              (cmd),
      .status           (status),
      .residue          (rsp_chan.residue)
   );

endmodule

`default_nettype wire

@@ design/mexp_controller.sv @@
`default_nettype none

module mexp_controller import mexp_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL    = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.start_op = OP_SQUARE;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.modulus_zero ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.step = 1'b1;
            if (status.mul_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.exp_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.start    = 1'b1;
               cmd.start_op = status.exp_lsb ? OP_MULT : OP_SQUARE;
               state_in     = ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ design/mexp_datapath.sv @@
`default_nettype none

module mexp_datapath import mexp_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_write_enable,
   input  wire word_type        csr_write_data,
   input  wire word_type        base_value,
   input  wire word_type        exponent,
   input  wire ctrl_cmd_type    cmd,
   output ctrl_status_type      status,
   output word_type             residue
);

   localparam int SUM_BITS = WORD_BITS + 2;
   typedef logic [SUM_BITS-1:0] sum_type;

   word_type  modulus_ff;
   word_type  acc_ff;
   word_type  sq_ff;
   word_type  exp_ff;
   word_type  r_ff;
   word_type  a_ff;
   word_type  b_ff;
   count_type count_ff;
   op_type    op_ff;
   word_type  residue_ff;

   word_type  one_mod;
   word_type  addend;
   sum_type   total;
   sum_type   mod_once;
   sum_type   mod_twice;
   sum_type   reduced;
   word_type  r_next;

   // One mod m: zero when the modulus is one.
   assign one_mod = (modulus_ff == word_type'(1)) ? '0 : word_type'(1);

   // One add-and-double step: 2r + a*bit stays below 3m, so at most two
   // subtractions of m bring it back into range.
   assign addend    = b_ff[WORD_BITS-1] ? a_ff : '0;
   assign total     = {1'b0, r_ff, 1'b0} + {2'b00, addend};
   assign mod_once  = {2'b00, modulus_ff};
   assign mod_twice = {1'b0, modulus_ff, 1'b0};

   always_comb begin
      if (total >= mod_twice) begin
         reduced = total - mod_twice;
      end else if (total >= mod_once) begin
         reduced = total - mod_once;
      end else begin
         reduced = total;
      end
   end

   assign r_next = reduced[WORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= word_type'(1);
      end else if (csr_write_enable) begin
         modulus_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff   <= one_mod;
         exp_ff   <= exponent;
         a_ff     <= one_mod;
         b_ff     <= base_value;
         r_ff     <= '0;
         count_ff <= '0;
         op_ff    <= OP_REDUCE;
      end else if (cmd.start) begin
         a_ff     <= (cmd.start_op == OP_MULT) ? acc_ff : sq_ff;
         b_ff     <= sq_ff;
         r_ff     <= '0;
         count_ff <= '0;
         op_ff    <= cmd.start_op;
      end else if (cmd.step) begin
         r_ff     <= r_next;
         b_ff     <= {b_ff[WORD_BITS-2:0], 1'b0};
         count_ff <= count_ff + count_type'(1);
         if (count_ff == LAST_COUNT) begin
            case (op_ff)
               OP_MULT: begin
                  acc_ff    <= r_next;
                  exp_ff[0] <= 1'b0;
               end
               OP_SQUARE: begin
                  sq_ff  <= r_next;
                  exp_ff <= {1'b0, exp_ff[WORD_BITS-1:1]};
               end
               default: begin
                  sq_ff <= r_next;
               end
            endcase
         end
      end
      if (cmd.publish) begin
         residue_ff <= (modulus_ff == '0) ? '0 : acc_ff;
      end
   end

   assign status.modulus_zero = (modulus_ff == '0);
   assign status.mul_last     = (count_ff == LAST_COUNT);
   assign status.exp_zero     = (exp_ff == '0);
   assign status.exp_lsb      = exp_ff[0];
   assign residue             = residue_ff;

endmodule

`default_nettype wire

@@ design/mexp_checker.sv @@
`default_nettype none

`include "modular_exponentiation_assert.svh"

module mexp_checker import mexp_pkg::*; (
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     req_valid,
   input wire logic     req_ready,
   input wire logic     rsp_valid,
   input wire logic     rsp_ready,
   input wire word_type rsp_residue
);

   // Only one item is in work, so a request transfer closes the request side.
   `MEXP_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // A new response is only published from the finishing state, never from idle.
   `MEXP_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid), $past(!req_ready), "response appeared out of idle")

   `MEXP_ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "stalled response dropped")

   `MEXP_ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_residue), "stalled residue changed")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_residue (rsp_chan.residue)
);

`default_nettype wire
